FILE: src/bxds_pkg.sv
package bxds_pkg;

   localparam int MaxSrcSize  = 4096;
   localparam int MaxDstWidth = 1024;
   localparam int FracBits    = 16;

   localparam int SizeW  = 13;   // 1..4096
   localparam int TwW    = 11;   // 1..1024
   localparam int ColW   = 12;   // source column index
   localparam int RowW   = 12;   // source row index
   localparam int OColW  = 10;   // output column index
   localparam int ORowW  = 12;   // output row index
   localparam int StepW  = 29;   // 13.16 step, integer part up to 4096
   localparam int CntW   = 26;   // window area up to 4096*4096
   localparam int DivW   = 32;

   // register indexes on the csr port
   localparam logic [1:0] RegSrcWidth  = 2'd0;
   localparam logic [1:0] RegSrcHeight = 2'd1;
   localparam logic [1:0] RegDstWidth  = 2'd2;
   localparam logic [1:0] RegDstHeight = 2'd3;

   typedef struct packed {
      logic [SizeW-1:0] source_width;
      logic [SizeW-1:0] source_height;
      logic [TwW-1:0]   target_width;
      logic [SizeW-1:0] target_height;
   } cfg_type;

   typedef struct packed {
      logic clear_step;
      logic take_pixel;
      logic latch_cfg;     // latch sizes, start column step divide
      logic store_col;     // keep column step, start row step divide
      logic store_row;
      logic calc_cnt;
      logic mem_read;
      logic accumulate;    // also starts the average divide on a window end
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic frame_start;
      logic emit;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

FILE: src/bxds_div.sv
module bxds_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bxds_pkg::DivW-1:0]  dividend,
   input  logic [bxds_pkg::DivW-1:0]  divisor,
   output logic [bxds_pkg::DivW-1:0]  quotient,
   output logic                       done
);
   import bxds_pkg::*;

   // restoring divide, one quotient bit per cycle
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [4:0]      step_ff, step_in;
   logic [DivW-1:0] rem_ff, rem_in;
   logic [DivW-1:0] quo_ff, quo_in;
   logic [DivW-1:0] dvs_ff, dvs_in;
   logic [DivW:0]   shifted;
   logic [DivW:0]   diff;
   logic            ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DivW-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DivW-1:0] : shifted[DivW-1:0];
         quo_in  = {quo_ff[DivW-2:0], ge};
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

FILE: src/bxds_ctrl.sv
module bxds_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bxds_pkg::sts_type sts,
   output bxds_pkg::cmd_type cmd
);
   import bxds_pkg::*;

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_LATCH = 10'b0000000100,
      S_DIVC  = 10'b0000001000,
      S_DIVR  = 10'b0000010000,
      S_WIN   = 10'b0000100000,
      S_READ  = 10'b0001000000,
      S_ACC   = 10'b0010000000,
      S_DIVA  = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take_pixel = 1'b1;
               state_in = sts.frame_start ? S_LATCH : S_READ;
            end
         end
         S_LATCH: begin
            cmd.latch_cfg = 1'b1;
            state_in = S_DIVC;
         end
         S_DIVC: begin
            if (sts.div_done) begin
               cmd.store_col = 1'b1;
               state_in = S_DIVR;
            end
         end
         S_DIVR: begin
            if (sts.div_done) begin
               cmd.store_row = 1'b1;
               state_in = S_WIN;
            end
         end
         S_WIN: begin
            cmd.calc_cnt = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.accumulate = 1'b1;
            state_in = sts.emit ? S_DIVA : S_IDLE;
         end
         S_DIVA: begin
            if (sts.div_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/bxds_dp.sv
module bxds_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  bxds_pkg::cfg_type           cfg,
   input  bxds_pkg::cmd_type           cmd,
   output bxds_pkg::sts_type           sts,
   input  logic [7:0]                  req_pixel,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_average,
   output logic [bxds_pkg::OColW-1:0]  rsp_out_column,
   output logic [bxds_pkg::ORowW-1:0]  rsp_out_row,
   output logic                        rsp_frame_last
);
   import bxds_pkg::*;

   // frame geometry latched at frame start
   logic [SizeW-1:0] lat_w_ff, lat_h_ff, lat_th_ff;
   logic [TwW-1:0]   lat_tw_ff;
   logic [StepW-1:0] col_step_ff, row_step_ff;
   logic [CntW-1:0]  cnt_ff;

   // raster position
   logic [ColW-1:0]  src_col_ff, src_col_in;
   logic [RowW-1:0]  src_row_ff, src_row_in;
   logic [OColW-1:0] out_col_ff, out_col_in;
   logic [ORowW-1:0] out_row_ff, out_row_in;
   logic [StepW-1:0] col_pos_ff, col_pos_in;
   logic [StepW-1:0] row_pos_ff, row_pos_in;

   logic [7:0]       pixel_ff;
   logic [31:0]      rd_ff;
   logic [OColW-1:0] clr_ff;

   logic [OColW-1:0] pend_col_ff;
   logic [ORowW-1:0] pend_row_ff;
   logic             pend_last_ff;

   logic             rsp_valid_ff;
   logic [7:0]       rsp_avg_ff;
   logic [OColW-1:0] rsp_col_ff;
   logic [ORowW-1:0] rsp_row_ff;
   logic             rsp_last_ff;

   logic [31:0] sums_mem [MaxDstWidth];

   // clamped sizes
   logic [SizeW-1:0] w_c, h_c, twmax_c, th_c;
   logic [TwW-1:0]   tw_c;

   always_comb begin
      if (cfg.source_width == '0) w_c = SizeW'(1);
      else if (cfg.source_width > SizeW'(MaxSrcSize)) w_c = SizeW'(MaxSrcSize);
      else w_c = cfg.source_width;
      if (cfg.source_height == '0) h_c = SizeW'(1);
      else if (cfg.source_height > SizeW'(MaxSrcSize)) h_c = SizeW'(MaxSrcSize);
      else h_c = cfg.source_height;
      twmax_c = (w_c < SizeW'(MaxDstWidth)) ? w_c : SizeW'(MaxDstWidth);
      if (cfg.target_width == '0) tw_c = TwW'(1);
      else if ({2'b0, cfg.target_width} > twmax_c) tw_c = twmax_c[TwW-1:0];
      else tw_c = cfg.target_width;
      if (cfg.target_height == '0) th_c = SizeW'(1);
      else if (cfg.target_height > h_c) th_c = h_c;
      else th_c = cfg.target_height;
   end

   // window sizes, zero counts as one
   logic [SizeW-1:0] win_x, win_y;
   assign win_x = (col_step_ff[StepW-1:FracBits] == '0) ? SizeW'(1)
                                                        : col_step_ff[StepW-1:FracBits];
   assign win_y = (row_step_ff[StepW-1:FracBits] == '0) ? SizeW'(1)
                                                        : row_step_ff[StepW-1:FracBits];

   // window membership of the current pixel
   logic [SizeW:0] c_x, cs_x, ce_x, r_y, rs_y, re_y;
   logic           incol, inrow, col_end, row_end, inwin;
   logic [31:0]    sum;

   always_comb begin
      c_x  = {2'b0, src_col_ff};
      cs_x = {1'b0, col_pos_ff[StepW-1:FracBits]};
      ce_x = cs_x + {1'b0, win_x};
      r_y  = {2'b0, src_row_ff};
      rs_y = {1'b0, row_pos_ff[StepW-1:FracBits]};
      re_y = rs_y + {1'b0, win_y};
      incol   = (c_x >= cs_x) && (c_x < ce_x);
      inrow   = (r_y >= rs_y) && (r_y < re_y);
      col_end = incol && (c_x == ce_x - 1'b1);
      row_end = inrow && (r_y == re_y - 1'b1);
      inwin   = incol && inrow;
      sum     = rd_ff + {24'b0, pixel_ff};
   end

   // shared divider
   logic            div_start;
   logic [DivW-1:0] div_dvd, div_dvs, div_quo;
   logic            div_done;

   always_comb begin
      div_start = 1'b0;
      div_dvd   = sum;
      div_dvs   = {{(DivW-CntW){1'b0}}, cnt_ff};
      if (cmd.latch_cfg) begin
         div_start = 1'b1;
         div_dvd   = {{(DivW-SizeW-FracBits){1'b0}}, w_c, {FracBits{1'b0}}};
         div_dvs   = {{(DivW-TwW){1'b0}}, tw_c};
      end else if (cmd.store_col) begin
         div_start = 1'b1;
         div_dvd   = {{(DivW-SizeW-FracBits){1'b0}}, lat_h_ff, {FracBits{1'b0}}};
         div_dvs   = {{(DivW-SizeW){1'b0}}, lat_th_ff};
      end else if (cmd.accumulate && inwin && col_end && row_end) begin
         div_start = 1'b1;
      end
   end

   bxds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (div_quo),
      .done     (div_done)
   );

   // raster and window position update
   always_comb begin
      src_col_in = src_col_ff;
      src_row_in = src_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (cmd.latch_cfg) begin
         out_col_in = '0;
         out_row_in = '0;
         col_pos_in = '0;
         row_pos_in = '0;
      end else if (cmd.accumulate) begin
         if (col_end && ({1'b0, out_col_ff} + 1'b1 < lat_tw_ff)) begin
            out_col_in = out_col_ff + 1'b1;
            col_pos_in = col_pos_ff + col_step_ff;
         end
         if ({1'b0, src_col_ff} + 1'b1 >= lat_w_ff) begin
            src_col_in = '0;
            out_col_in = '0;
            col_pos_in = '0;
            if (row_end && ({1'b0, out_row_ff} + 1'b1 < lat_th_ff)) begin
               out_row_in = out_row_ff + 1'b1;
               row_pos_in = row_pos_ff + row_step_ff;
            end
            if ({1'b0, src_row_ff} + 1'b1 >= lat_h_ff) begin
               src_row_in = '0;
               out_row_in = '0;
               row_pos_in = '0;
            end else begin
               src_row_in = src_row_ff + 1'b1;
            end
         end else begin
            src_col_in = src_col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
         if (cmd.load_out) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_pixel) pixel_ff <= req_pixel;
      if (cmd.latch_cfg) begin
         lat_w_ff  <= w_c;
         lat_h_ff  <= h_c;
         lat_tw_ff <= tw_c;
         lat_th_ff <= th_c;
      end
      if (cmd.store_col) col_step_ff <= div_quo[StepW-1:0] + 1'b1;
      if (cmd.store_row) row_step_ff <= div_quo[StepW-1:0] + 1'b1;
      if (cmd.calc_cnt) cnt_ff <= win_x * win_y;
      if (cmd.accumulate) begin
         pend_col_ff  <= out_col_ff;
         pend_row_ff  <= out_row_ff;
         pend_last_ff <= ({1'b0, out_col_ff} + 1'b1 == lat_tw_ff)
                      && ({1'b0, out_row_ff} + 1'b1 == lat_th_ff);
      end
      if (cmd.load_out) begin
         rsp_avg_ff  <= div_quo[7:0];
         rsp_col_ff  <= pend_col_ff;
         rsp_row_ff  <= pend_row_ff;
         rsp_last_ff <= pend_last_ff;
      end
   end

   // column accumulator line
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         sums_mem[clr_ff] <= '0;
      end else if (cmd.accumulate && inwin) begin
         sums_mem[out_col_ff] <= (col_end && row_end) ? '0 : sum;
      end
      if (cmd.mem_read) rd_ff <= sums_mem[out_col_ff];
   end

   always_comb begin
      sts.clear_done  = (clr_ff == '1);
      sts.frame_start = (src_col_ff == '0) && (src_row_ff == '0);
      sts.emit        = inwin && col_end && row_end;
      sts.div_done    = div_done;
      sts.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_average    = rsp_avg_ff;
   assign rsp_out_column = rsp_col_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

FILE: src/box_average_downscaler.sv
// Area-averaging grey image downscaler. Source pixels (8 bit) enter in
// raster order on req_*; each output pixel is the truncated mean of a
// window of (col step>>16) by (row step>>16) source pixels, with 13.16 steps
// (src<<16)/dst+1 recomputed from the csr registers when the first pixel of
// a frame is accepted, so csr writes made during a frame apply to the next.
// A result leaves on rsp_* with its output column, row and a frame_last flag.
// Sequence: a pixel that closes no window passes through accept, accumulator
// read and accumulate; one that closes a window adds a bit-serial divide in
// the shared radix-2 divider and the result load, which waits while rsp_* is
// stalled, and the first pixel of a frame adds a size latch, two step divides
// and the window area.
// After reset the 1024-entry column accumulator line is zeroed by a clearing
// pass during which req_stall stays high; csr writes are taken at any time.
module box_average_downscaler (
   input  logic                        clock,
   input  logic                        reset,
   // pixel input
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_pixel,
   // result output
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_average,
   output logic [bxds_pkg::OColW-1:0]  rsp_out_column,
   output logic [bxds_pkg::ORowW-1:0]  rsp_out_row,
   output logic                        rsp_frame_last,
   // register writes
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [bxds_pkg::SizeW-1:0]  csr_wdata
);
   import bxds_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;

   // csr port never back-pressures
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width  <= SizeW'(800);
         cfg_ff.source_height <= SizeW'(600);
         cfg_ff.target_width  <= TwW'(100);
         cfg_ff.target_height <= SizeW'(30);
      end else if (csr_valid) begin
         unique case (csr_index)
            RegSrcWidth:  cfg_ff.source_width  <= csr_wdata;
            RegSrcHeight: cfg_ff.source_height <= csr_wdata;
            RegDstWidth:  cfg_ff.target_width  <= csr_wdata[TwW-1:0];
            RegDstHeight: cfg_ff.target_height <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer: one pixel at a time
   bxds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // position tracking, accumulator line, divider, result register
   bxds_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .cmd            (cmd),
      .sts            (sts),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_average    (rsp_average),
      .rsp_out_column (rsp_out_column),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
